// File: rtl/ekt_pkg.sv
// Shared types, constants and fixed-point helpers for the encoder Kalman tracker.
// Used by ekt_div, encoder_kalman_tracker and the dv files. No dependencies.
package ekt_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_PREDICT = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_RESET   = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_POS_NOISE  = 2'd0;
  localparam logic [1:0] CFG_VEL_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;
  localparam logic [1:0] CFG_QUANT_STEP = 2'd3;

  // Fixed-point constants
  localparam logic signed [31:0] ONE_Q24       = 32'sd16777216;
  localparam logic signed [34:0] BLEND_W       = 35'sd335544;
  localparam logic signed [34:0] KEEP_W        = 35'sd16441672;   // 1.0 - blend
  localparam logic signed [34:0] ONE_Q24_W     = 35'sd16777216;
  localparam logic [15:0]        QUANT_DEFAULT = 16'd26;
  localparam logic [31:0]        MEAS_NOISE_RST = 32'd16777216;

  localparam logic signed [71:0] MAX32 = 72'sd2147483647;
  localparam logic signed [71:0] MIN32 = -72'sd2147483648;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [33:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > MAX32) r = 32'sh7fffffff;
    else if (x < MIN32) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // floor(x / 2^24 + 1/2)
  function automatic logic signed [45:0] rnd24(input logic signed [69:0] x);
    logic signed [70:0] t;
    t = 71'(x) + 71'sd8388608;
    return t[69:24];
  endfunction

endpackage

// File: rtl/ekt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nothing but the clock; used by encoder_kalman_tracker.
module ekt_mul (
  input  logic               clk,
  input  logic signed [34:0] a,
  input  logic signed [34:0] b,
  output logic signed [69:0] prod
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/ekt_div.sv
// Iterative restoring divider for the Kalman gains: sat32((num * 2^24) / den),
// truncated toward zero, one quotient bit per cycle. Depends on ekt_pkg.
module ekt_div
  import ekt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [55:0] rem;
  logic [64:0] dsh;
  logic [31:0] q;
  logic [4:0]  cnt;
  logic        busy;
  logic        neg;
  logic        done;
  logic [31:0] mag;
  logic        fits;

  // magnitude of the numerator
  assign mag  = req.num[31] ? 32'(-33'(req.num)) : 32'(req.num);
  assign fits = {9'b0, rem} >= dsh;

  // one restoring step per cycle, quotient bits 31 down to 0
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.num[31];
        rem  <= {mag, 24'b0};
        dsh  <= {req.den, 31'b0};
        q    <= '0;
      end else if (busy) begin
        if (fits) rem <= rem - dsh[55:0];
        q   <= {q[30:0], fits};
        dsh <= dsh >> 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top quotient bit set: magnitude beyond signed 32-bit range, saturate
  always_comb begin
    rsp.done = done;
    if (q[31]) rsp.quo = neg ? 32'sh80000000 : 32'sh7fffffff;
    else if (neg) rsp.quo = -$signed(q);
    else rsp.quo = $signed(q);
  end

endmodule

// File: rtl/encoder_kalman_tracker.sv
// Encoder angle/velocity tracker: two-state constant-velocity Kalman filter.
// Top level; depends on ekt_pkg, ekt_mul and ekt_div.
//
// Input stream (s_*): one transaction per item. s_tuser is the item kind
// (predict, measurement update, reset to given state); s_tdata carries dt,
// commanded velocity, angle value and start velocity.
// Output stream (m_*): one transaction per item with the angle and velocity
// estimates after the item, and in m_tuser a flag that the item changed state.
// Configuration: cfg_we/cfg_index/cfg_data write the noise registers and the
// quantization step; write only while the tracker is idle.
// Datapath: items are handled one at a time on a shared 35x35 multiplier and a
// one-bit-per-cycle divider. A predict runs the steps S_P0 to S_P9, a
// gain-computing update two gain divisions and then the correction steps; a
// reset, skipped or gated item goes straight to the finish step.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register; the next item is accepted meanwhile, but its result
// is held back until the receiver has taken the earlier one.
// Reset (rst, synchronous) clears the state to zero angle and velocity,
// identity covariance, not initialized, and registers to their defaults.
module encoder_kalman_tracker
  import ekt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,   // dt[23:0], cmd_velocity[55:24], angle_value[87:56],
                                  // start_velocity[119:88]
  input  logic [1:0]   s_tuser,   // kind[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // angle_estimate[31:0], velocity_estimate[63:32]
  output logic [0:0]   m_tuser,   // item_applied[0]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_UD0, S_UW0, S_UD1, S_UW1,
    S_UM0, S_UM1, S_UM2, S_UM3, S_UM4, S_UM5,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [31:0] position_noise, velocity_noise, measurement_noise;
  logic [15:0] quant_step;

  // filter state
  logic signed [31:0] angle_st, vel_st, last_meas, cov_a, cov_c, cov_v;
  logic               tracker_ready;

  // latched item
  kind_t              in_kind;
  logic [23:0]        in_dt;
  logic signed [31:0] in_cmd, in_ang, in_vel;

  // working registers
  logic signed [69:0] acc;
  logic signed [32:0] t1;
  logic signed [45:0] t2;
  logic signed [31:0] y, k0, k1;
  logic [33:0]        s_reg;
  logic               applied;

  // shared units
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;
  div_req_t           dreq;
  div_rsp_t           drsp;

  ekt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  ekt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // decode-time values
  logic signed [32:0] dmeas, ydiff;
  logic [32:0]        dabs;
  logic [15:0]        qeff;
  logic signed [33:0] ssum;
  logic               gated;
  logic signed [34:0] dt_w;
  logic signed [31:0] upd_ca, upd_cv;

  assign dmeas = 33'(in_ang) - 33'(last_meas);
  assign dabs  = dmeas[32] ? 33'(-dmeas) : dmeas;
  assign qeff  = (quant_step == 16'd0) ? QUANT_DEFAULT : quant_step;
  assign gated = {dabs, 1'b0} < {18'b0, qeff};
  assign ydiff = 33'(in_ang) - 33'(angle_st);
  assign ssum  = 34'(cov_a) + $signed({2'b0, measurement_noise});
  assign dt_w  = $signed({11'b0, in_dt});
  assign upd_ca = sat32(72'(rnd24(prod)));
  assign upd_cv = sat32(72'(cov_v) - 72'(rnd24(prod)));

  assign s_tready = (state == S_IDLE);

  // operand selection for the shared multiplier and the divider
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P0:  begin mul_a = 35'(vel_st); mul_b = KEEP_W; end
      S_P1:  begin mul_a = 35'(in_cmd); mul_b = BLEND_W; end
      S_P3:  begin mul_a = 35'(vel_st); mul_b = dt_w; end
      S_P4:  begin mul_a = dt_w; mul_b = 35'(cov_v); end
      S_P6:  begin mul_a = dt_w; mul_b = (35'(cov_c) <<< 1) + 35'(t1); end
      S_P7:  begin mul_a = $signed({3'b0, position_noise}); mul_b = dt_w; end
      S_P8:  begin mul_a = $signed({3'b0, velocity_noise}); mul_b = dt_w; end
      S_UM0: begin mul_a = 35'(k0); mul_b = 35'(y); end
      S_UM1: begin mul_a = 35'(k1); mul_b = 35'(y); end
      S_UM2: begin mul_a = ONE_Q24_W - 35'(k0); mul_b = 35'(cov_a); end
      S_UM3: begin mul_a = ONE_Q24_W - 35'(k0); mul_b = 35'(cov_c); end
      S_UM4: begin mul_a = 35'(k1); mul_b = 35'(cov_c); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    dreq.start = (state == S_UD0) || (state == S_UD1);
    dreq.num   = (state == S_UD1) ? cov_c : cov_a;
    dreq.den   = s_reg;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      position_noise    <= '0;
      velocity_noise    <= '0;
      measurement_noise <= MEAS_NOISE_RST;
      quant_step        <= QUANT_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_NOISE:  position_noise    <= cfg_data;
        CFG_VEL_NOISE:  velocity_noise    <= cfg_data;
        CFG_MEAS_NOISE: measurement_noise <= cfg_data;
        CFG_QUANT_STEP: quant_step        <= cfg_data[15:0];
        default:        quant_step        <= quant_step;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      applied       <= 1'b0;
      angle_st      <= '0;
      vel_st        <= '0;
      last_meas     <= '0;
      cov_a         <= ONE_Q24;
      cov_c         <= '0;
      cov_v         <= ONE_Q24;
      tracker_ready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_kind <= kind_t'(s_tuser);
            in_dt   <= s_tdata[23:0];
            in_cmd  <= s_tdata[55:24];
            in_ang  <= s_tdata[87:56];
            in_vel  <= s_tdata[119:88];
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (in_kind)
            KIND_PREDICT: begin
              if (tracker_ready && in_dt != 24'd0) begin
                applied <= 1'b1;
                state   <= S_P0;
              end else begin
                applied <= 1'b0;
                state   <= S_FINISH;
              end
            end
            KIND_UPDATE: begin
              if (!tracker_ready) begin
                angle_st      <= in_ang;
                vel_st        <= '0;
                last_meas     <= in_ang;
                cov_a         <= ONE_Q24;
                cov_c         <= '0;
                cov_v         <= ONE_Q24;
                tracker_ready <= 1'b1;
                applied       <= 1'b1;
                state         <= S_FINISH;
              end else if (!gated) begin
                last_meas <= in_ang;
                y         <= sat32(72'(ydiff));
                s_reg     <= (ssum < 34'sd1) ? 34'd1 : 34'(ssum);
                applied   <= 1'b1;
                state     <= S_UD0;
              end else begin
                applied <= 1'b0;
                state   <= S_FINISH;
              end
            end
            KIND_RESET: begin
              angle_st      <= in_ang;
              vel_st        <= in_vel;
              last_meas     <= in_ang;
              cov_a         <= ONE_Q24;
              cov_c         <= '0;
              cov_v         <= ONE_Q24;
              tracker_ready <= 1'b1;
              applied       <= 1'b1;
              state         <= S_FINISH;
            end
            default: begin
              applied <= 1'b0;
              state   <= S_FINISH;
            end
          endcase
        end
        // predict: velocity blend, angle advance, covariance growth
        S_P0: state <= S_P1;
        S_P1: begin
          acc   <= prod;
          state <= S_P2;
        end
        S_P2: begin
          vel_st <= sat32(72'(rnd24(acc + prod)));
          state  <= S_P3;
        end
        S_P3: state <= S_P4;
        S_P4: begin
          angle_st <= sat32(72'(angle_st) + 72'(rnd24(prod)));
          state    <= S_P5;
        end
        S_P5: begin
          t1    <= 33'(rnd24(prod));
          state <= S_P6;
        end
        S_P6: state <= S_P7;
        S_P7: begin
          t2    <= rnd24(prod);
          cov_c <= sat32(72'(cov_c) + 72'(t1));
          state <= S_P8;
        end
        S_P8: begin
          cov_a <= sat32(72'(cov_a) + 72'(t2) + 72'(rnd24(prod)));
          state <= S_P9;
        end
        S_P9: begin
          cov_v <= sat32(72'(cov_v) + 72'(rnd24(prod)));
          state <= S_FINISH;
        end
        // update: two gain divisions, then state and covariance correction
        S_UD0: state <= S_UW0;
        S_UW0: begin
          if (drsp.done) begin
            k0    <= drsp.quo;
            state <= S_UD1;
          end
        end
        S_UD1: state <= S_UW1;
        S_UW1: begin
          if (drsp.done) begin
            k1    <= drsp.quo;
            state <= S_UM0;
          end
        end
        S_UM0: state <= S_UM1;
        S_UM1: begin
          angle_st <= sat32(72'(angle_st) + 72'(rnd24(prod)));
          state    <= S_UM2;
        end
        S_UM2: begin
          vel_st <= sat32(72'(vel_st) + 72'(rnd24(prod)));
          state  <= S_UM3;
        end
        S_UM3: begin
          cov_a <= upd_ca[31] ? 32'sd0 : upd_ca;
          state <= S_UM4;
        end
        S_UM4: begin
          cov_c <= sat32(72'(rnd24(prod)));
          state <= S_UM5;
        end
        S_UM5: begin
          cov_v <= upd_cv[31] ? 32'sd0 : upd_cv;
          state <= S_FINISH;
        end
        // hand the result to the output register once it is free
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {vel_st, angle_st};
            m_tuser  <= applied;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_UW0 || state == S_UW1))
    else $error("divider result outside a gain wait");

  // an accepted transaction blocks the input on the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after acceptance");

  // until initialized the filter keeps its reset state
  assert property (@(posedge clk) disable iff (rst)
    !tracker_ready |-> (cov_a == ONE_Q24 && cov_c == 32'sd0 &&
                        cov_v == ONE_Q24 && angle_st == 32'sd0 && vel_st == 32'sd0))
    else $error("state changed before initialization");

  // a result is only loaded from the finish step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result loaded outside the finish step");

endmodule

// File: dv/encoder_kalman_tracker_chk.sv
// Checker for the encoder Kalman tracker: mirrors filter state, predicts each output
// transaction and compares it field by field. Depends on ekt_pkg.
`timescale 1ns / 100ps
module encoder_kalman_tracker_chk
  import ekt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] vel;
    logic               applied;
  } estimate_t;

  estimate_t est_q[$];

  logic [31:0] pos_noise, vel_noise, meas_noise;
  logic [15:0] qstep;
  longint ang, vel, last_meas, p00, p01, p11;
  bit ready;

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor(x / 2^24 + 1/2); 128-bit intermediate keeps products exact
  function automatic longint round24(input logic signed [127:0] x);
    logic signed [127:0] t;
    t = (x + 128'sd8388608) >>> 24;
    return longint'(t);
  endfunction

  function automatic void load_track(input longint a, input longint v);
    ang = a; vel = v; last_meas = a;
    p00 = 64'sd16777216; p01 = 0; p11 = 64'sd16777216;
    ready = 1;
  endfunction

  // Advance the tracker by one item and return its estimate
  function automatic estimate_t track_item(input logic [1:0] k, input logic [119:0] d);
    longint dt, cmd, mv, sv, t1, t2, delta, y, s, k0, k1, q, np00, o01;
    logic signed [127:0] wide;
    estimate_t e;
    dt  = longint'(d[23:0]);
    cmd = longint'($signed(d[55:24]));
    mv  = longint'($signed(d[87:56]));
    sv  = longint'($signed(d[119:88]));
    e.applied = 0;
    if (k == KIND_PREDICT) begin
      if (ready && dt != 0) begin
        wide = 128'(vel) * 128'sd16441672 + 128'(cmd) * 128'sd335544;
        vel = clip32(round24(wide));
        ang = clip32(ang + round24(128'(vel) * 128'(dt)));
        t1 = round24(128'(dt) * 128'(p11));
        t2 = round24(128'(dt) * (128'(2 * p01) + 128'(t1)));
        p00 = clip32(p00 + t2 + round24(128'(longint'(pos_noise)) * 128'(dt)));
        p01 = clip32(p01 + t1);
        p11 = clip32(p11 + round24(128'(longint'(vel_noise)) * 128'(dt)));
        e.applied = 1;
      end
    end else if (k == KIND_UPDATE) begin
      q = (qstep == 0) ? 26 : longint'(qstep);
      if (!ready) begin
        load_track(mv, 0);
        e.applied = 1;
      end else begin
        delta = mv - last_meas;
        if (delta < 0) delta = -delta;
        if (2 * delta >= q) begin
          last_meas = mv;
          y = clip32(mv - ang);
          s = p00 + longint'(meas_noise);
          if (s < 1) s = 1;
          k0 = clip32((p00 * 64'sd16777216) / s);
          k1 = clip32((p01 * 64'sd16777216) / s);
          ang = clip32(ang + round24(128'(k0) * 128'(y)));
          vel = clip32(vel + round24(128'(k1) * 128'(y)));
          o01 = p01;
          np00 = clip32(round24(128'(64'sd16777216 - k0) * 128'(p00)));
          p01 = clip32(round24(128'(64'sd16777216 - k0) * 128'(o01)));
          p11 = clip32(p11 - round24(128'(k1) * 128'(o01)));
          p00 = np00;
          if (p00 < 0) p00 = 0;
          if (p11 < 0) p11 = 0;
          e.applied = 1;
        end
      end
    end else if (k == KIND_RESET) begin
      load_track(mv, sv);
      e.applied = 1;
    end
    e.angle = ang[31:0];
    e.vel = vel[31:0];
    return e;
  endfunction

  estimate_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      pos_noise <= 0; vel_noise <= 0; meas_noise <= MEAS_NOISE_RST; qstep <= QUANT_DEFAULT;
      ang = 0; vel = 0; last_meas = 0; p00 = 64'sd16777216; p01 = 0; p11 = 64'sd16777216;
      ready = 0;
      est_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POS_NOISE:  pos_noise <= cfg_data;
          CFG_VEL_NOISE:  vel_noise <= cfg_data;
          CFG_MEAS_NOISE: meas_noise <= cfg_data;
          CFG_QUANT_STEP: qstep <= cfg_data[15:0];
          default: ;
        endcase
      end
      // Output transaction against oldest prediction
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got.angle = m_tdata[31:0];
        got.vel = m_tdata[63:32];
        got.applied = m_tuser[0];
        if (est_q.size() == 0) begin
          $display("%0t: unexpected result angle=%0d vel=%0d applied=%0d",
                   $time, got.angle, got.vel, got.applied);
          fail_count <= fail_count + 1;
        end else begin
          want = est_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected angle=%0d vel=%0d applied=%0d, got %0d %0d %0d",
                     $time, want.angle, want.vel, want.applied,
                     got.angle, got.vel, got.applied);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Input transaction: predict its estimate
      if (s_tvalid && s_tready) begin
        est_q.push_back(track_item(s_tuser, s_tdata));
      end
      pending <= est_q.size();
    end
  end

endmodule

// File: dv/encoder_kalman_tracker_tb.sv
// Testbench top for the encoder Kalman tracker: clock, reset, item stimulus and
// register writes. Depends on ekt_pkg, encoder_kalman_tracker and its checker.
`timescale 1ns / 100ps
module encoder_kalman_tracker_tb;
  import ekt_pkg::*;

  // kind code the tracker ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [119:0] s_tdata;   // dt, cmd_velocity, angle_value, start_velocity
  logic [1:0]   s_tuser;   // kind
  logic         m_tvalid, m_tready;
  logic [63:0]  m_tdata;   // angle_estimate, velocity_estimate
  logic [0:0]   m_tuser;   // item_applied
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count, pending, results_seen;
  int           cycles;
  bit           no_idle;
  int           items_sent;
  logic signed [31:0] track_angle;

  encoder_kalman_tracker dut (.*);
  encoder_kalman_tracker_chk chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= no_idle || ($urandom_range(99) >= 37);
  end

  // valid stays high after acceptance until the next idle cycle or drain
  task automatic send_item(input logic [1:0] k, input logic [23:0] dt,
                           input logic [31:0] cmd, input logic [31:0] av,
                           input logic [31:0] sv);
    while (!no_idle && $urandom_range(99) < 37) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= k;
    s_tdata <= {sv, av, cmd, dt};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain_results;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_edge32;
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed tracking: predicts and near-track updates, with occasional noise
  task automatic random_phase(input int n, input bit wide_dt);
    logic [31:0] v;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_item(KIND_PREDICT,
                              wide_dt ? 24'($urandom) : 24'($urandom_range(20000)),
                              ($urandom_range(3) == 0) ? rand_edge32()
                                : 32'($signed($urandom_range(400000)) - 200000),
                              $urandom, $urandom);
        4, 5, 6: begin
          v = track_angle + 32'($signed($urandom_range(4000)) - 2000);
          track_angle = v;
          send_item(KIND_UPDATE, 24'($urandom), $urandom, v, $urandom);
        end
        7: send_item(KIND_UPDATE, 24'($urandom), $urandom, rand_edge32(), $urandom);
        8: begin
          track_angle = $urandom;
          send_item(KIND_RESET, 24'($urandom), $urandom, track_angle, rand_edge32());
        end
        default: send_item(KIND_UNUSED, 24'($urandom), $urandom, $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0; no_idle = 0; items_sent = 0;
    track_angle = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: uninitialized predict, first update, gating, extremes, unused kind
    send_item(KIND_PREDICT, 24'hffffff, 32'h7fffffff, 0, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h100, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h10c, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h10d, 0);
    send_item(KIND_PREDICT, 24'd0, 32'h1000, 0, 0);
    send_item(KIND_PREDICT, 24'hffffff, 32'h7fffffff, 0, 0);
    send_item(KIND_PREDICT, 24'hffffff, 32'h80000000, 0, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h80000000, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h7fffffff, 0);
    send_item(KIND_RESET, 24'd0, 0, 32'h7fffffff, 32'h7fffffff);
    repeat (4) send_item(KIND_PREDICT, 24'hffffff, 32'h7fffffff, 0, 0);
    send_item(KIND_UPDATE, 24'd0, 0, 32'h80000000, 0);
    send_item(KIND_RESET, 24'hffffff, 32'hffffffff, 32'h80000000, 32'h80000000);
    send_item(KIND_UNUSED, 24'hffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    drain_results();

    // Large noise, zero quantization step (default), tiny R
    write_reg(CFG_POS_NOISE, 32'hffffffff);
    write_reg(CFG_VEL_NOISE, 32'hffffffff);
    write_reg(CFG_MEAS_NOISE, 32'd1);
    write_reg(CFG_QUANT_STEP, 32'd0);
    send_item(KIND_RESET, 24'd0, 0, 0, 0);
    random_phase(150, 1);
    drain_results();

    // Moderate noise with no idling
    no_idle = 1;
    write_reg(CFG_POS_NOISE, 32'd4000);
    write_reg(CFG_VEL_NOISE, 32'd200000);
    write_reg(CFG_MEAS_NOISE, 32'd8000000);
    write_reg(CFG_QUANT_STEP, 32'd26);
    random_phase(150, 0);
    no_idle = 0;
    drain_results();

    // Coarse quantization, huge R, random registers
    write_reg(CFG_POS_NOISE, $urandom);
    write_reg(CFG_VEL_NOISE, $urandom);
    write_reg(CFG_MEAS_NOISE, 32'hffffffff);
    write_reg(CFG_QUANT_STEP, 32'hffff);
    random_phase(150, 0);
    drain_results();

    write_reg(CFG_POS_NOISE, 0);
    write_reg(CFG_VEL_NOISE, 0);
    write_reg(CFG_MEAS_NOISE, 32'd16777216);
    write_reg(CFG_QUANT_STEP, $urandom_range(65535, 1));
    random_phase(150, 1);
    drain_results();

    $display("Ran %0d items, %0d results checked across five register settings,",
             items_sent, results_seen);
    $display("covering predicts, gated and applied updates, resets and the unused kind.");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/ekt_pkg.sv
rtl/ekt_mul.sv
rtl/ekt_div.sv
rtl/encoder_kalman_tracker.sv
dv/encoder_kalman_tracker_chk.sv
dv/encoder_kalman_tracker_tb.sv
